/* design/bfea_pkg.sv */
// Package: sizes, codes and channel types of the best-fit extent allocator.
`timescale 1ns / 1ps
`default_nettype none
package bfea_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_EXTENTS  = 16;

  localparam int IDX_W = $clog2(MAX_EXTENTS);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int OFS_W = $clog2(PAGE_BYTES);
  localparam int LEN_W = OFS_W + 1;
  localparam int SUM_W = LEN_W + 1;

  localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(2 * PAGE_BYTES - 1);
  localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);
  localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HEADER_BYTES);

  // Operation codes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_MERGE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ZERO  = 2'd1;
  localparam logic [1:0] STAT_NOFIT = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [LEN_W-1:0] request_size;
    logic [OFS_W-1:0] release_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFS_W-1:0] granted_offset;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             skip;
    logic [IDX_W-1:0] last_idx;
  } sts_t;

endpackage
`default_nettype wire

/* design/bfea_ctrl.sv */
// Controller: sequences load, table scan and finish of one request.
`timescale 1ns / 1ps
`default_nettype none
module bfea_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output bfea_pkg::cmd_t     cmd,
  input  bfea_pkg::sts_t     sts
);
  import bfea_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (sts.skip || idx_r == sts.last_idx) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && start;
  assign cmd.step   = (state_r == S_SCAN) && !sts.skip;
  assign cmd.finish = (state_r == S_FINISH);
  assign cmd.idx    = idx_r;

endmodule
`default_nettype wire

/* design/bfea_dp.sv */
// Datapath: extent table, best-fit search, insert pass and merge compaction.
`timescale 1ns / 1ps
`default_nettype none
module bfea_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  bfea_pkg::in_item_t  in_item,
  input  bfea_pkg::cmd_t      cmd,
  output bfea_pkg::sts_t      sts,
  output logic                out_strobe,
  output bfea_pkg::out_item_t out_item
);
  import bfea_pkg::*;

  logic [OFS_W-1:0] start_r [MAX_EXTENTS];
  logic [LEN_W-1:0] len_r   [MAX_EXTENTS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  in_item_t         item_r;

  // scan state: found/inserted flag, held extent, best candidate, write index
  logic             flag_r, flag_nxt;
  logic [OFS_W-1:0] hold_start_r, hold_start_nxt;
  logic [LEN_W-1:0] hold_len_r, hold_len_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [LEN_W-1:0] best_rem_r, best_rem_nxt;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic             strobe_r, strobe_nxt;
  out_item_t        out_r, out_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [OFS_W-1:0] wr_start;
  logic [LEN_W-1:0] wr_len;

  logic [OFS_W-1:0] rd_start;
  logic [LEN_W-1:0] rd_len;
  logic [LEN_W-1:0] req;
  logic [SUM_W-1:0] need;
  logic [LEN_W-1:0] rem;
  logic [SUM_W-1:0] merge_sum;
  logic [SUM_W-1:0] hold_end;
  logic [LEN_W-1:0] merge_len;
  logic             full;

  assign rd_start  = start_r[cmd.idx];
  assign rd_len    = len_r[cmd.idx];
  assign req       = (item_r.request_size < HDR_LEN) ? HDR_LEN : item_r.request_size;
  assign need      = {1'b0, req} + {1'b0, HDR_LEN};
  assign rem       = LEN_W'({1'b0, rd_len} - need);
  assign merge_sum = {1'b0, hold_len_r} + {1'b0, rd_len};
  assign merge_len = (merge_sum > {1'b0, LEN_CAP}) ? LEN_CAP : merge_sum[LEN_W-1:0];
  assign hold_end  = {2'b0, hold_start_r} + {1'b0, hold_len_r};
  assign full      = (cnt_r >= CNT_W'(MAX_EXTENTS));

  // status to controller
  always_comb begin
    sts.skip     = 1'b0;
    sts.last_idx = IDX_W'(cnt_r - 1'b1);
    case (item_r.mode)
      MODE_ALLOC: sts.skip = (item_r.request_size == '0);
      MODE_FREE: begin
        sts.skip     = full;
        sts.last_idx = cnt_r[IDX_W-1:0];
      end
      MODE_MERGE: sts.skip = 1'b0;
      default:    sts.skip = 1'b1;
    endcase
  end

  // per-step and finish logic
  always_comb begin
    cnt_nxt        = cnt_r;
    flag_nxt       = flag_r;
    hold_start_nxt = hold_start_r;
    hold_len_nxt   = hold_len_r;
    best_idx_nxt   = best_idx_r;
    best_rem_nxt   = best_rem_r;
    widx_nxt       = widx_r;
    strobe_nxt     = 1'b0;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_idx         = cmd.idx;
    wr_start       = hold_start_r;
    wr_len         = hold_len_r;

    if (cmd.load) begin
      flag_nxt = 1'b0;
      widx_nxt = '0;
    end

    if (cmd.step) begin
      case (item_r.mode)
        MODE_ALLOC: begin
          // best fit, first entry wins on ties
          if ({1'b0, rd_len} >= need && (!flag_r || rem < best_rem_r)) begin
            flag_nxt       = 1'b1;
            best_idx_nxt   = cmd.idx;
            best_rem_nxt   = rem;
            hold_start_nxt = rd_start;
            hold_len_nxt   = rd_len;
          end
        end
        MODE_FREE: begin
          // single pass: insert, then ripple the displaced entries up
          if (!flag_r && ({1'b0, cmd.idx} == cnt_r || item_r.release_offset < rd_start)) begin
            wr_en          = 1'b1;
            wr_start       = item_r.release_offset;
            wr_len         = req;
            flag_nxt       = 1'b1;
            hold_start_nxt = rd_start;
            hold_len_nxt   = rd_len;
          end else if (flag_r) begin
            wr_en          = 1'b1;
            hold_start_nxt = rd_start;
            hold_len_nxt   = rd_len;
          end
        end
        MODE_MERGE: begin
          // compaction: accumulate touching extents, write out on a gap
          if (cmd.idx == '0) begin
            hold_start_nxt = rd_start;
            hold_len_nxt   = rd_len;
          end else if (hold_end == {2'b0, rd_start}) begin
            hold_len_nxt = merge_len;
          end else begin
            wr_en          = 1'b1;
            wr_idx         = widx_r;
            widx_nxt       = widx_r + 1'b1;
            hold_start_nxt = rd_start;
            hold_len_nxt   = rd_len;
          end
        end
        default: ;
      endcase
    end

    if (cmd.finish) begin
      strobe_nxt = 1'b1;
      out_nxt    = '{status: STAT_OK, granted_offset: '0};
      case (item_r.mode)
        MODE_ALLOC: begin
          if (item_r.request_size == '0) begin
            out_nxt.status = STAT_ZERO;
          end else if (!flag_r) begin
            out_nxt.status = STAT_NOFIT;
          end else begin
            wr_en                  = 1'b1;
            wr_idx                 = best_idx_r;
            wr_len                 = hold_len_r - req;
            out_nxt.granted_offset = OFS_W'(hold_end - {1'b0, req});
          end
        end
        MODE_FREE: begin
          if (full) begin
            out_nxt.status = STAT_FULL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        MODE_MERGE: begin
          wr_en   = 1'b1;
          wr_idx  = widx_r;
          cnt_nxt = CNT_W'(widx_r) + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // extent table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      len_r[0]   <= PAGE_LEN;
    end else if (wr_en) begin
      start_r[wr_idx] <= wr_start;
      len_r[wr_idx]   <= wr_len;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= CNT_W'(1);
      strobe_r <= 1'b0;
      flag_r   <= 1'b0;
      widx_r   <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
      flag_r   <= flag_nxt;
      widx_r   <= widx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    hold_start_r <= hold_start_nxt;
    hold_len_r   <= hold_len_nxt;
    best_idx_r   <= best_idx_nxt;
    best_rem_r   <= best_rem_nxt;
    out_r        <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire

/* design/best_fit_extent_allocator_top.sv */
// Top level of the best-fit extent allocator.
//
//  channel  ports                    transfer when
//  in       start, busy, in_item     start high and busy low at a rising edge
//  out      out_strobe, out_item     out_strobe high, one cycle per result
//
// A request scans the table one entry at a time, as the table has a single
// read port, and free also visits the slot after the last extent; zero
// allocate, full-table free and mode 3 skip the scan and go to finish.
// The result appears the cycle busy drops; a new request may start then.
// Reset (synchronous, rst_n low) leaves one extent covering the whole page.
// The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_extent_allocator_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  bfea_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output bfea_pkg::out_item_t out_item
);
  import bfea_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfea_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  bfea_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

/* design/bfea_checker.sv */
// Port-level checker for the allocator top, bound to it.
`timescale 1ns / 1ps
`default_nettype none
module bfea_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_strobe,
  input wire bfea_pkg::out_item_t out_item
);
  import bfea_pkg::*;

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result never shows while a request is in work
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");

  // busy ends exactly with the result
  a_fell_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe) else $error("busy dropped without result");

  // a grant offset only comes with ok status
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status != STAT_OK |-> out_item.granted_offset == '0)
    else $error("offset on failed request");

endmodule

bind best_fit_extent_allocator_top bfea_checker u_bfea_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire

/* verif/tb_best_fit_extent_allocator_top.sv */
// Testbench: directed table and random traffic checked against a best-fit allocator predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_best_fit_extent_allocator_top;
  import bfea_pkg::*;

  localparam int N_RANDOM    = 430;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_TICKS = 64;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  typedef struct {
    int unsigned ofs;
    int unsigned len;
  } grant_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  // Predictor copy of the free-extent table
  int unsigned ext_start [MAX_EXTENTS];
  int unsigned ext_len [MAX_EXTENTS];
  int unsigned ext_cnt;

  out_item_t   pending_q [$];
  stim_row_t   dir_rows [$];
  grant_t      live_grants [$];
  int unsigned n_errors = 0;
  int unsigned idle_ticks = 0;
  bit          burst_mode = 1'b0;

  best_fit_extent_allocator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic int unsigned cap_len(input int unsigned v);
    return (v > int'(LEN_CAP)) ? int'(LEN_CAP) : v;
  endfunction

  // Advance the table model by one request and return the result
  function automatic out_item_t predict_alloc_table(input in_item_t it);
    out_item_t   res;
    int unsigned req, need, best, best_rem, len, pos, i;
    bit          found;
    res = '0;
    req = 0; need = 0; best = 0; best_rem = 0; found = 1'b0; len = 0; pos = 0;
    case (it.mode)
      MODE_ALLOC: begin
        if (it.request_size == 0) begin
          res.status = STAT_ZERO;
        end else begin
          req  = (it.request_size < HEADER_BYTES) ? HEADER_BYTES : it.request_size;
          need = req + HEADER_BYTES;
          for (i = 0; i < ext_cnt; i++) begin
            if (ext_len[i] >= need && (!found || ext_len[i] - need < best_rem)) begin
              found = 1'b1;
              best = i;
              best_rem = ext_len[i] - need;
            end
          end
          if (!found) begin
            res.status = STAT_NOFIT;
          end else begin
            res.status = STAT_OK;
            res.granted_offset = OFS_W'(ext_start[best] + ext_len[best] - req);
            ext_len[best] -= req;
          end
        end
      end
      MODE_FREE: begin
        if (ext_cnt >= MAX_EXTENTS) begin
          res.status = STAT_FULL;
        end else begin
          len = cap_len((it.request_size < HEADER_BYTES) ? HEADER_BYTES : it.request_size);
          pos = ext_cnt;
          for (i = 0; i < ext_cnt; i++) begin
            if (it.release_offset < ext_start[i]) begin
              pos = i;
              break;
            end
          end
          for (i = ext_cnt; i > pos; i--) begin
            ext_start[i] = ext_start[i-1];
            ext_len[i]   = ext_len[i-1];
          end
          ext_start[pos] = it.release_offset;
          ext_len[pos]   = len;
          ext_cnt++;
        end
      end
      MODE_MERGE: begin
        i = 0;
        while (i + 1 < ext_cnt) begin
          if (ext_start[i] + ext_len[i] == ext_start[i+1]) begin
            ext_len[i] = cap_len(ext_len[i] + ext_len[i+1]);
            for (pos = i + 1; pos + 1 < ext_cnt; pos++) begin
              ext_start[pos] = ext_start[pos+1];
              ext_len[pos]   = ext_len[pos+1];
            end
            ext_cnt--;
            ext_start[ext_cnt] = 0;
            ext_len[ext_cnt]   = 0;
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Present one item and hold start until the transfer
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   got;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = predict_alloc_table(it);
    pending_q.push_back(typed ? want : got);
    if (it.mode == MODE_ALLOC && got.status == STAT_OK) begin
      live_grants.push_back('{ofs: got.granted_offset,
                              len: (it.request_size < HEADER_BYTES) ? HEADER_BYTES
                                                                    : it.request_size});
    end
  endtask

  function automatic void add_row(input logic [1:0] mode, input int unsigned size,
                                  input int unsigned ofs, input bit typed,
                                  input logic [1:0] st, input int unsigned gofs);
    stim_row_t r;
    r.item  = '{mode: mode, request_size: LEN_W'(size), release_offset: OFS_W'(ofs)};
    r.typed = typed;
    r.want  = '{status: st, granted_offset: OFS_W'(gofs)};
    dir_rows.push_back(r);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned r, k;
    it = '0;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it.mode = MODE_ALLOC;
      k = $urandom_range(0, 19);
      it.request_size = (k == 0) ? LEN_W'(0) : (k < 15) ? LEN_W'($urandom_range(1, 300))
                      : (k < 18) ? LEN_W'($urandom_range(301, 4096)) : LEN_W'($urandom);
    end else if (r < 75) begin
      it.mode = MODE_FREE;
      if (live_grants.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, live_grants.size() - 1);
        it.release_offset = OFS_W'(live_grants[k].ofs);
        it.request_size   = LEN_W'(live_grants[k].len);
        live_grants.delete(k);
      end else begin
        it.release_offset = OFS_W'($urandom);
        it.request_size   = LEN_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64));
      end
    end else if (r < 95) begin
      it.mode = MODE_MERGE;
      it.request_size = LEN_W'($urandom);
      it.release_offset = OFS_W'($urandom);
    end else begin
      it = in_item_t'($urandom);
      it.mode = 2'b11;
    end
    return it;
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_res = pending_q.pop_front();
        if (out_item.status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", out_item.status, exp_res.status));
        if (out_item.granted_offset !== exp_res.granted_offset)
          report($sformatf("granted_offset %0d, expected %0d",
                           out_item.granted_offset, exp_res.granted_offset));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      idle_ticks <= 0;
    end else begin
      idle_ticks <= idle_ticks + 1;
      if (idle_ticks >= STALL_LIMIT) begin
        $display("tb_best_fit_extent_allocator_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned k;
    ext_start = '{default: 0};
    ext_len   = '{default: 0};
    ext_len[0] = PAGE_BYTES;
    ext_cnt   = 1;

    // Directed table: extremes, every mode, special cases, then a full table
    add_row(MODE_ALLOC, 0,    0,    1, STAT_ZERO,  0);
    add_row(MODE_ALLOC, 4096, 4095, 1, STAT_NOFIT, 0);
    add_row(MODE_ALLOC, 4080, 0,    1, STAT_OK,    16);
    add_row(MODE_ALLOC, 1,    0,    1, STAT_NOFIT, 0);
    add_row(MODE_FREE,  4080, 16,   1, STAT_OK,    0);
    add_row(MODE_MERGE, 0,    0,    1, STAT_OK,    0);
    add_row(MODE_ALLOC, 1,    0,    1, STAT_OK,    4080);
    add_row(MODE_FREE,  0,    4080, 1, STAT_OK,    0);
    add_row(MODE_MERGE, 8191, 4095, 1, STAT_OK,    0);
    add_row(MODE_FREE,  0,    0,    1, STAT_OK,    0);
    add_row(MODE_FREE,  8191, 4095, 1, STAT_OK,    0);
    add_row(MODE_FREE,  4096, 2048, 0, STAT_OK,    0);
    add_row(2'b11,      8191, 4095, 1, STAT_OK,    0);
    add_row(MODE_ALLOC, 8000, 0,    0, STAT_OK,    0);
    for (k = 0; k < 12; k++) add_row(MODE_FREE, 1, 256 * k + 8, 0, STAT_OK, 0);
    add_row(MODE_FREE,  100,  1000, 1, STAT_FULL,  0);
    add_row(MODE_MERGE, 0,    0,    0, STAT_OK,    0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      send_item(rand_item(), 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_best_fit_extent_allocator_top OK");
    end else begin
      $display("tb_best_fit_extent_allocator_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
